/* src/blake_pkg.sv */
`timescale 1ns / 1ps

package blake_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREF,
      ST_ROUND,
      ST_FINAL,
      ST_PADSET,
      ST_PAD,
      ST_OUT
   } state_type;

   localparam logic [3:0] PERM [10][16] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
        4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
      '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
        4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
      '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
        4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
      '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
        4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
      '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
        4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
      '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
        4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
      '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
        4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
      '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
        4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
      '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
        4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
   };

   localparam logic [31:0] PI_WORDS [16] = '{
      32'h243f6a88, 32'h85a308d3, 32'h13198a2e, 32'h03707344,
      32'ha4093822, 32'h299f31d0, 32'h082efa98, 32'hec4e6c89,
      32'h452821e6, 32'h38d01377, 32'hbe5466cf, 32'h34e90c6c,
      32'hc0ac29b7, 32'hc97c50dd, 32'h3f84d5b5, 32'hb5470917
   };

   localparam logic [31:0] INIT_VALUE [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [3:0] LAST_ROUND = 4'd13;

endpackage

/* src/blake256_hash_engine_top.sv */
`timescale 1ns / 1ps

// BLAKE-256 hash engine, salt zero. Message bytes arrive one item at a time;
// a byte item is taken while the engine is idle, but one that completes a
// 64-byte block is compressed before the next item is taken. Compression runs
// one shared half-G unit (three 32-bit adds, xor and rotate) over 14 rounds of
// eight G functions, each G in two halves, after a prefetch step and before a
// chain-update step. A message-end item adds a padding pass that writes the
// remaining words of the 16-word message memory after a set-up step, then one
// or two compressions, then eight digest items, word 0
// first, each word holding its most significant digest byte in bits 31:24.
// The engine returns to the initial value after the last digest item.
module blake256_hash_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_message_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   blake_pkg::state_type state_ff, state_in;

   // control state
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [63:0] bit_ff, bit_in;
   logic [5:0]  count_ff, count_in;
   logic        fin_pend_ff, fin_pend_in;
   logic        two_pend_ff, two_pend_in;
   logic        out_pend_ff, out_pend_in;
   logic        second_ff, second_in;
   logic        skip_ff, skip_in;
   logic [3:0]  rnd_ff, rnd_in;
   logic [2:0]  g_ff, g_in;
   logic        half_ff, half_in;
   logic [3:0]  pw_ff, pw_in;
   logic [2:0]  oidx_ff, oidx_in;

   // payload
   logic [31:0] v_ff [16];
   logic [31:0] v_in [16];
   logic [31:0] acc_ff, acc_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] ctr_ff, ctr_in;
   logic        long_ff, long_in;

   // message memory, one word per four bytes, big-endian
   logic [31:0] msg_mem [16];
   logic [31:0] rd_q;
   logic        mem_we;
   logic [3:0]  mem_wa;
   logic [31:0] mem_wd;
   logic [3:0]  mem_ra;

   logic        req_fire, rsp_fire, last_step;
   logic [3:0]  nr, rr, nrr;
   logic [2:0]  ng;
   logic        nh;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign last_step = (rnd_ff == blake_pkg::LAST_ROUND) && (g_ff == 3'd7) && half_ff;

   // round index modulo ten for the permutation table
   assign rr  = (rnd_ff >= 4'd10) ? rnd_ff - 4'd10 : rnd_ff;
   assign nrr = (nr >= 4'd10) ? nr - 4'd10 : nr;

   // next step of the sequencer, used to prefetch its message word
   always_comb begin
      nr = rnd_ff;
      ng = g_ff;
      nh = 1'b0;
      if (state_ff != blake_pkg::ST_ROUND) begin
         nr = 4'd0;
         ng = 3'd0;
      end else if (!half_ff) begin
         nh = 1'b1;
      end else if (g_ff != 3'd7) begin
         ng = g_ff + 3'd1;
      end else begin
         nr = rnd_ff + 4'd1;
         ng = 3'd0;
      end
   end

   assign mem_ra = blake_pkg::PERM[nrr][{ng, nh}];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         msg_mem[mem_wa] <= mem_wd;
      end
      rd_q <= msg_mem[mem_ra];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         blake_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_byte_present && count_ff == 6'd63) begin
                  state_in = blake_pkg::ST_PREF;
               end else if (req_message_end) begin
                  state_in = blake_pkg::ST_PADSET;
               end
            end
         end
         blake_pkg::ST_PREF:   state_in = blake_pkg::ST_ROUND;
         blake_pkg::ST_ROUND: begin
            if (last_step) begin
               state_in = blake_pkg::ST_FINAL;
            end
         end
         blake_pkg::ST_FINAL: begin
            if (two_pend_ff) begin
               state_in = blake_pkg::ST_PAD;
            end else if (fin_pend_ff) begin
               state_in = blake_pkg::ST_PADSET;
            end else if (out_pend_ff) begin
               state_in = blake_pkg::ST_OUT;
            end else begin
               state_in = blake_pkg::ST_IDLE;
            end
         end
         blake_pkg::ST_PADSET: state_in = blake_pkg::ST_PAD;
         blake_pkg::ST_PAD: begin
            if (pw_ff == 4'd15) begin
               state_in = blake_pkg::ST_PREF;
            end
         end
         blake_pkg::ST_OUT: begin
            if (rsp_fire && oidx_ff == 3'd7) begin
               state_in = blake_pkg::ST_IDLE;
            end
         end
         default: state_in = blake_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   logic        col;
   logic [31:0] ga, gb, gc, gd, mk, ga2, gb2, gc2, gd2, dt, bt, partial, padw;
   logic [31:0] vt [16];
   logic [63:0] len_now;
   logic [31:0] word_in;

   always_comb begin
      req_ready = (state_ff == blake_pkg::ST_IDLE);
      rsp_valid = (state_ff == blake_pkg::ST_OUT);
      rsp_digest_word = h_ff[oidx_ff];
      rsp_word_index  = oidx_ff;
      rsp_last_word   = (oidx_ff == 3'd7);

      h_in        = h_ff;
      bit_in      = bit_ff;
      count_in    = count_ff;
      fin_pend_in = fin_pend_ff;
      two_pend_in = two_pend_ff;
      out_pend_in = out_pend_ff;
      second_in   = second_ff;
      skip_in     = skip_ff;
      rnd_in      = rnd_ff;
      g_in        = g_ff;
      half_in     = half_ff;
      pw_in       = pw_ff;
      oidx_in     = oidx_ff;
      v_in        = v_ff;
      acc_in      = acc_ff;
      len_in      = len_ff;
      ctr_in      = ctr_ff;
      long_in     = long_ff;
      mem_we      = 1'b0;
      mem_wa      = count_ff[5:2];
      mem_wd      = {acc_ff[23:0], req_data_byte};

      // half-G on fixed positions: columns use slot 0 of each row, diagonals
      // slot k of row k; rows rotate left after each full G
      col = (g_ff[2] == 1'b0);
      ga  = v_ff[0];
      gb  = col ? v_ff[4]  : v_ff[5];
      gc  = col ? v_ff[8]  : v_ff[10];
      gd  = col ? v_ff[12] : v_ff[15];
      mk  = rd_q ^ blake_pkg::PI_WORDS[blake_pkg::PERM[rr][{g_ff, ~half_ff}]];
      ga2 = ga + mk + gb;
      dt  = gd ^ ga2;
      gd2 = half_ff ? {dt[7:0], dt[31:8]} : {dt[15:0], dt[31:16]};
      gc2 = gc + gd2;
      bt  = gb ^ gc2;
      gb2 = half_ff ? {bt[6:0], bt[31:7]} : {bt[11:0], bt[31:12]};
      vt  = v_ff;
      vt[0] = ga2;
      if (col) begin
         vt[4] = gb2; vt[8] = gc2; vt[12] = gd2;
      end else begin
         vt[5] = gb2; vt[10] = gc2; vt[15] = gd2;
      end

      len_now = bit_ff + {55'd0, count_ff, 3'd0};

      // padded word for the partial position
      case (count_ff[1:0])
         2'd0:    partial = 32'h80000000;
         2'd1:    partial = {acc_ff[7:0], 8'h80, 16'h0000};
         2'd2:    partial = {acc_ff[15:0], 8'h80, 8'h00};
         default: partial = {acc_ff[23:0], 8'h80};
      endcase
      word_in = 32'd0;
      if (!second_ff && pw_ff == count_ff[5:2]) begin
         word_in = partial;
      end
      padw = word_in;
      if (second_ff || !long_ff) begin
         if (pw_ff == 4'd13) begin
            padw = word_in | 32'h00000001;
         end else if (pw_ff == 4'd14) begin
            padw = len_ff[63:32];
         end else if (pw_ff == 4'd15) begin
            padw = len_ff[31:0];
         end
      end

      case (state_ff)
         blake_pkg::ST_IDLE: begin
            if (req_valid && req_byte_present) begin
               acc_in   = {acc_ff[23:0], req_data_byte};
               mem_we   = (count_ff[1:0] == 2'd3);
               count_in = count_ff + 6'd1;
               if (count_ff == 6'd63) begin
                  bit_in      = bit_ff + 64'd512;
                  ctr_in      = bit_ff + 64'd512;
                  skip_in     = 1'b0;
                  fin_pend_in = req_message_end;
               end
            end
         end
         blake_pkg::ST_PADSET: begin
            len_in      = len_now;
            ctr_in      = len_now;
            skip_in     = (count_ff == 6'd0);
            long_in     = (count_ff[5:3] == 3'b111);
            two_pend_in = (count_ff[5:3] == 3'b111);
            out_pend_in = 1'b1;
            fin_pend_in = 1'b0;
            second_in   = 1'b0;
            pw_in       = count_ff[5:2];
         end
         blake_pkg::ST_PAD: begin
            mem_we = 1'b1;
            mem_wa = pw_ff;
            mem_wd = padw;
            pw_in  = pw_ff + 4'd1;
         end
         blake_pkg::ST_PREF: begin
            for (int i = 0; i < 8; i++) begin
               v_in[i] = h_ff[i];
            end
            for (int i = 0; i < 4; i++) begin
               v_in[8 + i] = blake_pkg::PI_WORDS[i];
            end
            v_in[12] = blake_pkg::PI_WORDS[4] ^ (skip_ff ? 32'd0 : ctr_ff[31:0]);
            v_in[13] = blake_pkg::PI_WORDS[5] ^ (skip_ff ? 32'd0 : ctr_ff[31:0]);
            v_in[14] = blake_pkg::PI_WORDS[6] ^ (skip_ff ? 32'd0 : ctr_ff[63:32]);
            v_in[15] = blake_pkg::PI_WORDS[7] ^ (skip_ff ? 32'd0 : ctr_ff[63:32]);
            rnd_in  = 4'd0;
            g_in    = 3'd0;
            half_in = 1'b0;
         end
         blake_pkg::ST_ROUND: begin
            if (half_ff) begin
               for (int r = 0; r < 4; r++) begin
                  for (int k = 0; k < 4; k++) begin
                     v_in[r * 4 + k] = vt[r * 4 + ((k + 1) % 4)];
                  end
               end
            end else begin
               v_in = vt;
            end
            rnd_in  = nr;
            g_in    = ng;
            half_in = nh;
         end
         blake_pkg::ST_FINAL: begin
            for (int i = 0; i < 8; i++) begin
               h_in[i] = h_ff[i] ^ v_ff[i] ^ v_ff[i + 8];
            end
            if (two_pend_ff) begin
               two_pend_in = 1'b0;
               second_in   = 1'b1;
               skip_in     = 1'b1;
               pw_in       = 4'd0;
            end
            oidx_in = 3'd0;
         end
         blake_pkg::ST_OUT: begin
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  h_in        = blake_pkg::INIT_VALUE;
                  bit_in      = 64'd0;
                  count_in    = 6'd0;
                  out_pend_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= blake_pkg::ST_IDLE;
         h_ff        <= blake_pkg::INIT_VALUE;
         bit_ff      <= 64'd0;
         count_ff    <= 6'd0;
         fin_pend_ff <= 1'b0;
         two_pend_ff <= 1'b0;
         out_pend_ff <= 1'b0;
         second_ff   <= 1'b0;
         skip_ff     <= 1'b0;
         rnd_ff      <= 4'd0;
         g_ff        <= 3'd0;
         half_ff     <= 1'b0;
         pw_ff       <= 4'd0;
         oidx_ff     <= 3'd0;
      end else begin
         state_ff    <= state_in;
         h_ff        <= h_in;
         bit_ff      <= bit_in;
         count_ff    <= count_in;
         fin_pend_ff <= fin_pend_in;
         two_pend_ff <= two_pend_in;
         out_pend_ff <= out_pend_in;
         second_ff   <= second_in;
         skip_ff     <= skip_in;
         rnd_ff      <= rnd_in;
         g_ff        <= g_in;
         half_ff     <= half_in;
         pw_ff       <= pw_in;
         oidx_ff     <= oidx_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      acc_ff  <= acc_in;
      len_ff  <= len_in;
      ctr_ff  <= ctr_in;
      long_ff <= long_in;
   end

   // never take an item while a digest is being delivered
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while digest pending");

   // digest words leave in order
   a_word_order: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last_word |=> rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest word order broken");

   // after the last word drop back to the initial state
   a_back_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_last_word |=> req_ready && count_ff == 6'd0 && bit_ff == 64'd0)
      else $error("engine not cleared after digest");

endmodule

/* tb/blake256_digest_checker.sv */
`timescale 1ns / 1ps

module blake256_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_message_end,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_digest_word,
   input  logic [2:0]  rsp_word_index,
   input  logic        rsp_last_word,
   output int          fail_count,
   output int          pending_words
);

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_item_type;

   logic [31:0]     hash_state [8];
   logic [7:0]      msg_block [64];
   logic [63:0]     bits_done;
   int              fill;
   bit              no_count;
   digest_item_type digest_queue [$];

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic mix_block(input logic [63:0] count);
      logic [31:0] v [16];
      logic [31:0] m [16];
      int a, b, c, d, p, q;
      for (int i = 0; i < 16; i++)
         m[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 0; i < 8; i++) begin
         v[i] = hash_state[i];
         v[i+8] = blake_pkg::PI_WORDS[i];
      end
      if (!no_count) begin
         v[12] ^= count[31:0];
         v[13] ^= count[31:0];
         v[14] ^= count[63:32];
         v[15] ^= count[63:32];
      end
      for (int r = 0; r < 14; r++)
         for (int g = 0; g < 8; g++) begin
            // columns first, then diagonals
            a = g % 4;
            b = (g < 4) ? 4 + g : 4 + (g + 1) % 4;
            c = (g < 4) ? 8 + g : 8 + (g + 2) % 4;
            d = (g < 4) ? 12 + g : 12 + (g + 3) % 4;
            p = blake_pkg::PERM[r % 10][2*g];
            q = blake_pkg::PERM[r % 10][2*g+1];
            v[a] = v[a] + (m[p] ^ blake_pkg::PI_WORDS[q]) + v[b];
            v[d] = ror(v[d] ^ v[a], 16);
            v[c] = v[c] + v[d];
            v[b] = ror(v[b] ^ v[c], 12);
            v[a] = v[a] + (m[q] ^ blake_pkg::PI_WORDS[p]) + v[b];
            v[d] = ror(v[d] ^ v[a], 8);
            v[c] = v[c] + v[d];
            v[b] = ror(v[b] ^ v[c], 7);
         end
      for (int i = 0; i < 8; i++)
         hash_state[i] ^= v[i] ^ v[i+8];
   endtask

   task automatic start_message();
      for (int i = 0; i < 8; i++) hash_state[i] = blake_pkg::INIT_VALUE[i];
      bits_done = '0;
      fill = 0;
      no_count = 0;
   endtask

   task automatic write_length(input logic [63:0] len);
      for (int i = 0; i < 8; i++) msg_block[56+i] = len[63-8*i -: 8];
   endtask

   task automatic take_item(input logic [7:0] data, input logic present, input logic fin);
      logic [63:0] len;
      if (present) begin
         msg_block[fill] = data;
         fill++;
         if (fill == 64) begin
            bits_done += 512;
            no_count = 0;
            mix_block(bits_done);
            fill = 0;
         end
      end
      if (!fin) return;
      len = bits_done + 64'(fill * 8);
      for (int i = fill; i < 64; i++) msg_block[i] = 8'h00;
      msg_block[fill] = 8'h80;
      if (fill <= 55) begin
         msg_block[55] |= 8'h01;
         write_length(len);
         no_count = (fill == 0);
         mix_block(len);
      end else begin
         no_count = 0;
         mix_block(len);
         for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
         msg_block[55] = 8'h01;
         write_length(len);
         no_count = 1;
         mix_block(len);
      end
      for (int i = 0; i < 8; i++)
         digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
      start_message();
   endtask

   always @(posedge clock) begin
      digest_item_type want;
      if (reset) begin
         fail_count = 0;
         digest_queue.delete();
         start_message();
      end else begin
         if (req_valid && req_ready)
            take_item(req_data_byte, req_byte_present, req_message_end);
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               $display("%0t: unexpected digest word %h", $time, rsp_digest_word);
               fail_count++;
            end else begin
               want = digest_queue.pop_front();
               if (want.word !== rsp_digest_word || want.index !== rsp_word_index ||
                   want.last !== rsp_last_word) begin
                  $display("%0t: expected %h/%0d/%0d got %h/%0d/%0d", $time, want.word,
                           want.index, want.last, rsp_digest_word, rsp_word_index,
                           rsp_last_word);
                  fail_count++;
               end
            end
         end
      end
      pending_words = digest_queue.size();
   end
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_byte_present;
   logic        req_message_end;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;
   int          fail_count;
   int          pending_words;
   int          send_idle_pct;
   int          recv_stall_pct;
   longint      cycle_count = 0;

   localparam longint CYCLE_LIMIT = 3000000;

   blake256_hash_engine_top uut (.*);
   blake256_digest_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Stall the digest side at random, at the rate of the current phase.
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // Offer one item, holding it until the engine accepts it. Idle first at random.
   task automatic send_item(input logic [7:0] data, input logic present, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= data;
      req_byte_present <= present;
      req_message_end  <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Send a message of the given length; the last byte may ride with the end flag.
   task automatic send_message(input int len, input bit fold_end);
      for (int i = 0; i < len; i++)
         send_item(8'($urandom), 1'b1, fold_end && i == len - 1);
      if (!fold_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 50) return $urandom_range(0, 12);
      if (r < 80) return $urandom_range(50, 70);
      return $urandom_range(0, 140);
   endfunction

   initial begin
      int sent;
      int len;
      int idle_set [4] = '{0, 74, 0, 28};
      int stall_set [4] = '{0, 0, 74, 28};
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_byte_present = 1'b0;
      req_message_end  = 1'b0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty message, a bare no-op item, byte and end together,
      // the 55/56 byte padding boundary, and a full block followed by end.
      send_message(0, 0);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_message(55, 1);
      send_message(56, 0);
      send_message(64, 0);
      send_message(63, 1);

      // Random messages, one idling phase after another.
      sent = 0;
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = idle_set[ph];
         recv_stall_pct = stall_set[ph];
         while (sent < (ph + 1) * 54) begin
            if ($urandom_range(19) == 0) begin
               // noise: item with neither byte nor end
               send_item(8'($urandom), 1'b0, 1'b0);
            end else begin
               len = pick_length();
               send_message(len, 1'($urandom_range(1)));
               sent += len + 1;
            end
         end
      end
      req_valid <= 1'b0;
      recv_stall_pct = 0;

      while (pending_words != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (fail_count == 0 && pending_words == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule

/* blake256_hash_engine_top.f */
src/blake_pkg.sv
src/blake256_hash_engine_top.sv
tb/blake256_digest_checker.sv
tb/tb.sv
